// ===== hdl/crc8wf_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8wf_pkg
// Shared types, constants and the CRC-8 byte update for the word framer.
// ----------------------------------------------------------------------------
package crc8wf_pkg;

  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam logic [7:0] CNT_MAX     = 8'hFF;
  localparam int         MAX_RESULTS = 3;
  localparam int         CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic DIR_CHECK  = 1'b0;
  localparam logic DIR_INSERT = 1'b1;

  // phase codes: bytes of the current word already taken
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;
  localparam logic [1:0] PH_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       check_done;
    logic       crc_ok;
    logic [7:0] error_count;
    logic       last;
  } res_t;

  typedef struct packed {
    logic                            load;
    logic [CNT_W-1:0]                count;
    res_t [MAX_RESULTS-1:0]          res;
  } bundle_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/crc8wf_if.sv =====
// ----------------------------------------------------------------------------
// crc8wf_if
// Valid/ready channels for stream bytes and result beats.
// ----------------------------------------------------------------------------
interface crc8wf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       passthrough;
  logic       end_of_transfer;

  modport source (output valid, in_byte, passthrough, end_of_transfer, input ready);
  modport sink   (input valid, in_byte, passthrough, end_of_transfer, output ready);
endinterface

interface crc8wf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       check_done;
  logic       crc_ok;
  logic [7:0] error_count;
  logic       last;

  modport source (output valid, out_byte, has_byte, check_done, crc_ok, error_count, last,
                  input ready);
  modport sink   (input valid, out_byte, has_byte, check_done, crc_ok, error_count, last,
                  output ready);
endinterface

// ===== hdl/crc8wf_core.sv =====
// ----------------------------------------------------------------------------
// crc8wf_core
// Framing state, CRC update and result bundle for one accepted byte.
// ----------------------------------------------------------------------------
module crc8wf_core import crc8wf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  input  logic    accept,
  input  logic    can_load,
  input  logic [7:0] in_byte,
  input  logic    passthrough,
  input  logic    end_of_transfer,
  output bundle_t bundle
);

  logic       direction;
  logic [1:0] phase;
  logic [15:0] held_bytes;
  logic [7:0] running_crc;
  logic [7:0] mismatch_count;

  logic [1:0]  phase_next;
  logic [15:0] held_bytes_next;
  logic [7:0]  running_crc_next;
  logic [7:0]  mismatch_count_next;
  logic [CNT_W-1:0] n;
  res_t [MAX_RESULTS-1:0] res;
  logic [7:0] crc_first;
  logic [7:0] crc_cont;
  logic       ok;
  logic [7:0] cnt_chk;

  assign crc_first = crc8_byte(CRC_INIT, in_byte);
  assign crc_cont  = crc8_byte(running_crc, in_byte);
  assign ok        = (in_byte == running_crc);
  assign cnt_chk   = (!ok && mismatch_count != CNT_MAX) ? mismatch_count + 8'd1
                                                        : mismatch_count;

  always_comb begin
    phase_next          = phase;
    held_bytes_next     = held_bytes;
    running_crc_next    = running_crc;
    mismatch_count_next = mismatch_count;
    n                   = '0;
    res                 = '0;

    if (direction == DIR_CHECK) begin
      if (phase == PH_START || phase == PH_SPARE) begin
        held_bytes_next  = {in_byte, 8'h00};
        running_crc_next = crc_first;
        phase_next       = PH_ONE;
      end else if (phase == PH_ONE) begin
        held_bytes_next  = {held_bytes[15:8], in_byte};
        running_crc_next = crc_cont;
        phase_next       = PH_TWO;
      end else begin
        mismatch_count_next = cnt_chk;
        res[0] = '{out_byte: held_bytes[15:8], has_byte: 1'b1, check_done: 1'b0,
                   crc_ok: 1'b0, error_count: cnt_chk, last: 1'b0};
        res[1] = '{out_byte: held_bytes[7:0], has_byte: 1'b1, check_done: 1'b1,
                   crc_ok: ok, error_count: cnt_chk, last: 1'b0};
        n                = CNT_W'(2);
        phase_next       = PH_START;
        running_crc_next = CRC_INIT;
      end
    end else begin
      if (passthrough) begin
        res[0] = '{out_byte: in_byte, has_byte: 1'b1, check_done: 1'b0,
                   crc_ok: 1'b0, error_count: mismatch_count, last: 1'b0};
        n = CNT_W'(1);
      end else if (phase != PH_ONE) begin
        held_bytes_next  = {in_byte, 8'h00};
        running_crc_next = crc_first;
        phase_next       = PH_ONE;
      end else begin
        res[0] = '{out_byte: held_bytes[15:8], has_byte: 1'b1, check_done: 1'b0,
                   crc_ok: 1'b0, error_count: mismatch_count, last: 1'b0};
        res[1] = '{out_byte: in_byte, has_byte: 1'b1, check_done: 1'b0,
                   crc_ok: 1'b0, error_count: mismatch_count, last: 1'b0};
        res[2] = '{out_byte: crc_cont, has_byte: 1'b1, check_done: 1'b0,
                   crc_ok: 1'b0, error_count: mismatch_count, last: 1'b0};
        n                = CNT_W'(3);
        phase_next       = PH_START;
        held_bytes_next  = '0;
        running_crc_next = CRC_INIT;
      end
    end

    if (end_of_transfer) begin
      // empty marker when nothing else goes out
      if (n == '0) begin
        res[0] = '{out_byte: 8'h00, has_byte: 1'b0, check_done: 1'b0,
                   crc_ok: 1'b0, error_count: mismatch_count, last: 1'b0};
        n = CNT_W'(1);
      end
      unique case (n)
        CNT_W'(1): res[0].last = 1'b1;
        CNT_W'(2): res[1].last = 1'b1;
        default:   res[2].last = 1'b1;
      endcase
      phase_next          = PH_START;
      held_bytes_next     = '0;
      running_crc_next    = CRC_INIT;
      mismatch_count_next = '0;
    end
  end

  assign bundle.load  = accept && (n != '0);
  assign bundle.count = n;
  assign bundle.res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= DIR_CHECK;
      phase          <= PH_START;
      held_bytes     <= '0;
      running_crc    <= CRC_INIT;
      mismatch_count <= '0;
    end else begin
      if (cfg_we) begin
        direction <= cfg_wdata;
      end
      if (accept) begin
        phase          <= phase_next;
        held_bytes     <= held_bytes_next;
        running_crc    <= running_crc_next;
        mismatch_count <= mismatch_count_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_transfer |=> phase == PH_START && mismatch_count == '0 &&
                                  running_crc == CRC_INIT)
    else $error("end of transfer did not return framing to start");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(accept && end_of_transfer) |=> mismatch_count >= $past(mismatch_count))
    else $error("mismatch count went down inside a transfer");

  a_accept_needs_room: assert property (@(posedge clk) disable iff (rst)
    accept |-> can_load)
    else $error("byte accepted with no room for its results");
`endif

endmodule

// ===== hdl/crc8wf_serializer.sv =====
// ----------------------------------------------------------------------------
// crc8wf_serializer
// Holds up to three result beats of one byte and sends them one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module crc8wf_serializer import crc8wf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  bundle_t bundle,
  output logic    can_load,
  crc8wf_out_if.source out_ch
);

  logic [CNT_W-1:0]       count;
  res_t [MAX_RESULTS-1:0] res;
  logic                   pop;

  assign pop      = out_ch.valid && out_ch.ready;
  // room when empty or the final beat leaves this cycle
  assign can_load = (count == '0) || (count == CNT_W'(1) && out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (bundle.load) begin
      count <= bundle.count;
    end else if (pop) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.load) begin
      res <= bundle.res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res[i] <= res[i+1];
      end
    end
  end

  assign out_ch.valid       = (count != '0);
  assign out_ch.out_byte    = res[0].out_byte;
  assign out_ch.has_byte    = res[0].has_byte;
  assign out_ch.check_done  = res[0].check_done;
  assign out_ch.crc_ok      = res[0].crc_ok;
  assign out_ch.error_count = res[0].error_count;
  assign out_ch.last        = res[0].last;

`ifndef ASSERT_OFF
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    bundle.load |=> count == $past(bundle.count))
    else $error("result bundle not loaded with its beat count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready && !bundle.load |=> count == $past(count))
    else $error("beat count changed while stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    bundle.load |-> count == '0 || (count == CNT_W'(1) && pop))
    else $error("bundle loaded over pending beats");
`endif

endmodule

// ===== hdl/crc8_word_framer_checker.sv =====
// The first result beat is registered and valid the cycle after its byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one beat and the output is
// ready; a byte that yields more beats holds off the next byte until its last beat leaves.
// Output drains one beat per cycle while ready; input is taken while the final beat leaves.
// Reset (rst, synchronous): direction to check mode, framing state, CRC to 0xFF,
// mismatch count to zero, beat buffer emptied.
// ----------------------------------------------------------------------------
// crc8_word_framer_checker
// CRC-8 (0x31, init 0xFF) word framer: checks and strips or inserts the CRC.
// ----------------------------------------------------------------------------
module crc8_word_framer_checker import crc8wf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  crc8wf_in_if.sink    byte_ch,
  crc8wf_out_if.source result_ch
);

  bundle_t bundle;
  logic    can_load;
  logic    accept;

  assign byte_ch.ready = can_load;
  assign accept        = byte_ch.valid && can_load;

  crc8wf_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .accept          (accept),
    .can_load        (can_load),
    .in_byte         (byte_ch.in_byte),
    .passthrough     (byte_ch.passthrough),
    .end_of_transfer (byte_ch.end_of_transfer),
    .bundle          (bundle)
  );

  crc8wf_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .bundle   (bundle),
    .can_load (can_load),
    .out_ch   (result_ch)
  );

endmodule
